[rtl/core/hspd_pkg.sv]
// Shared types and constants for the hall speed PI drive loop.
// Holds the item structs, register indexes and datapath widths.
// No dependencies.
package hspd_pkg;

	localparam int COUNT_BITS = 10;
	localparam int ACC_BITS   = 48;

	// Multiplier operands: unsigned 16-bit gain by signed 18-bit error
	localparam int MULA_W  = 16;
	localparam int MULB_W  = 18;
	localparam int PROD_W  = MULA_W + 1 + MULB_W;
	localparam int DELTA_W = PROD_W + 1;
	localparam int SUM_W   = ((ACC_BITS > DELTA_W) ? ACC_BITS : DELTA_W) + 1;
	localparam int FRAC_W  = 16;
	localparam int MAG_W   = ACC_BITS - FRAC_W;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_ERROR_GAIN      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PREV_ERROR_GAIN = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SPEED_SCALE     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DUTY_LIMIT      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_KICK_THRESHOLD  = 3'd4;

	localparam logic [15:0] RST_ERROR_GAIN      = 16'd9911;
	localparam logic [15:0] RST_PREV_ERROR_GAIN = 16'd9677;
	localparam logic [9:0]  RST_SPEED_SCALE     = 10'd125;
	localparam logic [11:0] RST_DUTY_LIMIT      = 12'd750;
	localparam logic [11:0] RST_KICK_THRESHOLD  = 12'd550;

	localparam logic ACT_HALL_EDGE = 1'b0;
	localparam logic ACT_TICK      = 1'b1;

	localparam logic [1:0] HALL_LINE_A = 2'd0;

	localparam logic [2:0] HALL_CODE_REV_LO = 3'd1;
	localparam logic [2:0] HALL_CODE_REV_HI = 3'd6;
	localparam logic [2:0] HALL_CODE_FWD_LO = 3'd2;
	localparam logic [2:0] HALL_CODE_FWD_HI = 3'd5;

	typedef struct packed {
		logic               action;
		logic [1:0]         hall_line;
		logic [2:0]         hall_code;
		logic signed [15:0] setpoint;
	} in_item_t;

	typedef struct packed {
		logic signed [15:0] measured_speed;
		logic [11:0]        duty;
		logic               drive_direction;
		logic               kick_request;
	} out_item_t;

	typedef struct packed {
		logic       edge_en;
		logic       clear;
		logic [1:0] line;
		logic [2:0] code;
	} hall_ctl_t;

	typedef struct packed {
		logic [COUNT_BITS-1:0] pole_count;
		logic                  sense;
	} hall_stat_t;

endpackage

[rtl/core/hall_speed_pi_drive_loop.sv]
// Top level of the hall speed PI drive loop: config registers, sequencer,
// shared multiplier datapath and output register. Uses hspd_pkg and
// hspd_hall_sense.
//
// channel | signals                      | moves
// --------+------------------------------+------------------------------
// in      | in_valid, in_ready, in_item  | hall edge or control tick
// out     | out_valid, out_ready, out_item | one result per control tick
// cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | register write
//
// A hall edge is counted as it is accepted and gives no result; in_ready is high
// whenever the sequencer is idle, also while a result waits.
// A control tick runs eight sequencer steps around one shared 17x18 multiplier;
// out_valid rises as the sequencer leaves its last step and in_ready returns on
// that same edge, so a tick holds the input until its result is registered.
// A tick whose result is ready holds in its last step until the output
// register is free. cfg_ready is always high.
// Reset clears the counter, sense, accumulator, previous error, direction
// and loads the register defaults.
module hall_speed_pi_drive_loop import hspd_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  in_item_t              in_item,
	output logic                  out_valid,
	input  logic                  out_ready,
	output out_item_t             out_item,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_SPD  = 4'd1;
	localparam logic [3:0] S_ERR  = 4'd2;
	localparam logic [3:0] S_MA   = 4'd3;
	localparam logic [3:0] S_MB   = 4'd4;
	localparam logic [3:0] S_SUB  = 4'd5;
	localparam logic [3:0] S_ACC  = 4'd6;
	localparam logic [3:0] S_MAG  = 4'd7;
	localparam logic [3:0] S_OUT  = 4'd8;

	logic [3:0] state_q;

	logic [15:0] error_gain_q;
	logic [15:0] prev_error_gain_q;
	logic [9:0]  speed_scale_q;
	logic [11:0] duty_limit_q;
	logic [11:0] kick_threshold_q;

	logic signed [MULB_W-1:0]   prev_err_q;
	logic signed [ACC_BITS-1:0] acc_q;
	logic                       dir_q;
	logic                       out_valid_q;
	out_item_t                  out_item_q;

	logic signed [15:0]         sp_q;
	logic signed [15:0]         speed_q;
	logic signed [MULB_W-1:0]   err_q;
	logic signed [PROD_W-1:0]   prod_q;
	logic signed [DELTA_W-1:0]  delta_q;
	logic [MAG_W-1:0]           mag_q;

	hall_ctl_t  hall_ctl;
	hall_stat_t hall_stat;

	logic in_fire;
	logic out_free;

	logic [MULA_W-1:0]        mul_a;
	logic signed [MULB_W-1:0] mul_b;
	logic signed [PROD_W-1:0] mul_p;

	logic [15:0]              spd_mag;
	logic signed [SUM_W-1:0]  acc_sum;
	logic signed [ACC_BITS-1:0] acc_next;
	logic [ACC_BITS-1:0]      acc_abs;
	logic [11:0]              clamped;

	assign in_ready  = (state_q == S_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	assign hall_ctl.edge_en = in_fire && (in_item.action == ACT_HALL_EDGE);
	assign hall_ctl.clear   = (state_q == S_SPD);
	assign hall_ctl.line    = in_item.hall_line;
	assign hall_ctl.code    = in_item.hall_code;

	hspd_hall_sense u_hall (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (hall_ctl),
		.stat   (hall_stat)
	);

	// Shared multiplier: count*scale, then the two PI products
	always_comb begin
		case (state_q)
			S_SPD: begin
				mul_a = MULA_W'(speed_scale_q);
				mul_b = $signed(MULB_W'(hall_stat.pole_count));
			end
			S_MA: begin
				mul_a = error_gain_q;
				mul_b = err_q;
			end
			S_MB: begin
				mul_a = prev_error_gain_q;
				mul_b = prev_err_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = $signed({1'b0, mul_a}) * mul_b;

	// halve the count product and saturate to the positive 16-bit range
	assign spd_mag = (|mul_p[PROD_W-1:16]) ? 16'h7FFF : {1'b0, mul_p[15:1]};

	// saturating accumulate: out of range when the top bits disagree
	assign acc_sum = SUM_W'(acc_q) + SUM_W'(delta_q);
	always_comb begin
		if ((&acc_sum[SUM_W-1:ACC_BITS-1]) || !(|acc_sum[SUM_W-1:ACC_BITS-1])) begin
			acc_next = acc_sum[ACC_BITS-1:0];
		end else if (acc_sum[SUM_W-1]) begin
			acc_next = {1'b1, {(ACC_BITS-1){1'b0}}};
		end else begin
			acc_next = {1'b0, {(ACC_BITS-1){1'b1}}};
		end
	end

	assign acc_abs = acc_q[ACC_BITS-1] ? (ACC_BITS'(0) - ACC_BITS'(acc_q)) : ACC_BITS'(acc_q);
	assign clamped = (mag_q > MAG_W'(duty_limit_q)) ? duty_limit_q : mag_q[11:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			error_gain_q      <= RST_ERROR_GAIN;
			prev_error_gain_q <= RST_PREV_ERROR_GAIN;
			speed_scale_q     <= RST_SPEED_SCALE;
			duty_limit_q      <= RST_DUTY_LIMIT;
			kick_threshold_q  <= RST_KICK_THRESHOLD;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_ERROR_GAIN:      error_gain_q      <= cfg_data;
				REG_PREV_ERROR_GAIN: prev_error_gain_q <= cfg_data;
				REG_SPEED_SCALE:     speed_scale_q     <= cfg_data[9:0];
				REG_DUTY_LIMIT:      duty_limit_q      <= cfg_data[11:0];
				REG_KICK_THRESHOLD:  kick_threshold_q  <= cfg_data[11:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			prev_err_q  <= '0;
			acc_q       <= '0;
			dir_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if ((state_q == S_OUT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_fire && (in_item.action == ACT_TICK)) begin
						state_q <= S_SPD;
					end
				end
				S_SPD: state_q <= S_ERR;
				S_ERR: state_q <= S_MA;
				S_MA:  state_q <= S_MB;
				S_MB: begin
					prev_err_q <= err_q;
					state_q    <= S_SUB;
				end
				S_SUB: state_q <= S_ACC;
				S_ACC: begin
					acc_q   <= acc_next;
					state_q <= S_MAG;
				end
				S_MAG: begin
					// zero drive holds the last direction
					if (acc_q != '0) begin
						dir_q <= !acc_q[ACC_BITS-1];
					end
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			sp_q <= in_item.setpoint;
		end
		case (state_q)
			S_SPD: speed_q <= hall_stat.sense ? $signed(spd_mag) : -$signed(spd_mag);
			S_ERR: err_q   <= MULB_W'(sp_q) - MULB_W'(speed_q);
			S_MA:  prod_q  <= mul_p;
			S_MB: begin
				delta_q <= DELTA_W'(prod_q);
				prod_q  <= mul_p;
			end
			S_SUB: delta_q <= delta_q - DELTA_W'(prod_q);
			S_MAG: mag_q   <= acc_abs[ACC_BITS-1:FRAC_W];
			S_OUT: begin
				if (out_free) begin
					out_item_q.measured_speed  <= speed_q;
					out_item_q.duty            <= duty_limit_q - clamped;
					out_item_q.drive_direction <= dir_q;
					out_item_q.kick_request    <= (clamped >= kick_threshold_q) &&
					                              (speed_q == '0);
				end
			end
			default: ;
		endcase
	end

	a_tick_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && (in_item.action == ACT_TICK) |=> state_q == S_SPD)
		else $error("tick item did not start the sequencer");

	a_edge_stays_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && (in_item.action == ACT_HALL_EDGE) |=> state_q == S_IDLE)
		else $error("hall edge item left the idle state");

	a_count_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SPD |=> hall_stat.pole_count == '0)
		else $error("pole count not cleared by tick");

	a_result_from_seq: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == S_OUT)
		else $error("result raised outside the final step");

	a_kick_needs_stall: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> !out_item_q.kick_request || (out_item_q.measured_speed == '0))
		else $error("kick raised with a moving rotor");

endmodule

[rtl/core/hspd_hall_sense.sv]
// Saturating pole counter and rotation sense latch.
// Driven by the sequencer in the top level; uses hspd_pkg.
module hspd_hall_sense import hspd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  hall_ctl_t  ctl,
	output hall_stat_t stat
);

	logic [COUNT_BITS-1:0] pole_count_q;
	logic                  sense_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pole_count_q <= '0;
			sense_q      <= 1'b0;
		end else begin
			if (ctl.clear) begin
				pole_count_q <= '0;
			end else if (ctl.edge_en && (pole_count_q != {COUNT_BITS{1'b1}})) begin
				pole_count_q <= pole_count_q + COUNT_BITS'(1);
			end
			// only line A carries the sense; other codes hold it
			if (ctl.edge_en && (ctl.line == HALL_LINE_A)) begin
				if ((ctl.code == HALL_CODE_REV_LO) || (ctl.code == HALL_CODE_REV_HI)) begin
					sense_q <= 1'b0;
				end else if ((ctl.code == HALL_CODE_FWD_LO) ||
				             (ctl.code == HALL_CODE_FWD_HI)) begin
					sense_q <= 1'b1;
				end
			end
		end
	end

	assign stat.pole_count = pole_count_q;
	assign stat.sense      = sense_q;

endmodule
